### hw/rtl/dmxtx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DMX512 transmitter package
// Shared types and constants for the frame transmitter core.
// ----------------------------------------------------------------------------
package dmxtx_pkg;

	// Width of period-sized values; holds break + MAB + a full frame of slots.
	localparam int unsigned PER_W = 23;

	localparam logic [19:0] MIN_BREAK_US  = 20'd92;
	localparam logic [19:0] MIN_MAB_US    = 20'd12;
	localparam logic [PER_W-1:0] MIN_PERIOD_US = PER_W'(1204);
	localparam logic [31:0] START_DELAY_US = 32'd4;

	localparam logic [19:0] RST_BREAK_US  = 20'd92;
	localparam logic [19:0] RST_MAB_US    = 20'd12;
	localparam logic [19:0] RST_PERIOD_US = 20'd25000;
	localparam logic [9:0]  RST_SLOTS     = 10'd512;

	// Register indexes on the configuration port (word address).
	localparam logic [1:0] REG_BREAK  = 2'd0;
	localparam logic [1:0] REG_MAB    = 2'd1;
	localparam logic [1:0] REG_PERIOD = 2'd2;
	localparam logic [1:0] REG_SLOTS  = 2'd3;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_BREAK = 3'd1,
		PH_MAB   = 3'd2,
		PH_DATA  = 3'd3,
		PH_INTER = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		MODE_TICK  = 2'd0,
		MODE_LOAD  = 2'd1,
		MODE_START = 2'd2,
		MODE_STOP  = 2'd3
	} mode_t;

	// Timing values derived from the configuration registers.
	typedef struct packed {
		logic [20:0]      brk_p1;
		logic [20:0]      mab_p1;
		logic [9:0]       slots;
		logic [PER_W-1:0] period;
		logic [PER_W-1:0] period_p4;
	} cfg_t;

	typedef struct packed {
		logic       break_active;
		logic       byte_valid;
		logic [7:0] byte_value;
		logic       load_accepted;
		logic       period_overrun;
		logic [2:0] phase;
	} res_t;

endpackage

### hw/rtl/dmxtx_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DMX512 transmitter configuration registers
// APB register file plus a two-stage pipeline that derives timing values.
// ----------------------------------------------------------------------------
module dmxtx_cfg #(
	parameter int unsigned MAX_SLOTS    = 512,
	parameter int unsigned SLOT_TIME_US = 44
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                hold,
	output dmxtx_pkg::cfg_t     cfg
);

	localparam int unsigned PW = dmxtx_pkg::PER_W;

	logic [19:0] break_q;
	logic [19:0] mab_q;
	logic [19:0] period_q;
	logic [9:0]  slots_q;
	logic [1:0]  hold_q;
	logic        wr_en;

	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			break_q  <= dmxtx_pkg::RST_BREAK_US;
			mab_q    <= dmxtx_pkg::RST_MAB_US;
			period_q <= dmxtx_pkg::RST_PERIOD_US;
			slots_q  <= dmxtx_pkg::RST_SLOTS;
			hold_q   <= 2'd0;
		end else begin
			if (wr_en) begin
				unique case (paddr[3:2])
					dmxtx_pkg::REG_BREAK:  break_q  <= pwdata[19:0];
					dmxtx_pkg::REG_MAB:    mab_q    <= pwdata[19:0];
					dmxtx_pkg::REG_PERIOD: period_q <= pwdata[19:0];
					dmxtx_pkg::REG_SLOTS:  slots_q  <= pwdata[9:0];
					default:               break_q  <= break_q;
				endcase
				hold_q <= 2'd3;
			end else if (hold_q != 2'd0) begin
				hold_q <= hold_q - 2'd1;
			end
		end
	end

	assign hold = (hold_q != 2'd0);

	always_comb begin
		unique case (paddr[3:2])
			dmxtx_pkg::REG_BREAK:  prdata = {12'd0, break_q};
			dmxtx_pkg::REG_MAB:    prdata = {12'd0, mab_q};
			dmxtx_pkg::REG_PERIOD: prdata = {12'd0, period_q};
			dmxtx_pkg::REG_SLOTS:  prdata = {22'd0, slots_q};
			default:               prdata = 32'd0;
		endcase
	end

	// Stage 1: clamp the registers and scale the slot count.
	logic [19:0]  brk_s1;
	logic [19:0]  mab_s1;
	logic [9:0]   slots_s1;
	logic [19:0]  req_s1;
	logic [PW-1:0] bm_s1;
	logic [PW-1:0] slot_t_s1;
	logic [19:0]  brk_c;
	logic [19:0]  mab_c;
	logic [9:0]   slots_c;

	always_comb begin
		brk_c   = (break_q < dmxtx_pkg::MIN_BREAK_US) ? dmxtx_pkg::MIN_BREAK_US : break_q;
		mab_c   = (mab_q < dmxtx_pkg::MIN_MAB_US) ? dmxtx_pkg::MIN_MAB_US : mab_q;
		slots_c = (32'(slots_q) > MAX_SLOTS) ? 10'(MAX_SLOTS) : slots_q;
	end

	always_ff @(posedge clk) begin
		brk_s1    <= brk_c;
		mab_s1    <= mab_c;
		slots_s1  <= slots_c;
		req_s1    <= period_q;
		bm_s1     <= PW'(brk_c) + PW'(mab_c);
		slot_t_s1 <= PW'(PW'(slots_c) + PW'(1)) * PW'(SLOT_TIME_US);
	end

	// Stage 2: frame length and effective period.
	logic [PW-1:0] pkt;
	logic [PW-1:0] alt;
	logic [PW-1:0] per_c;
	logic          req_ok;

	always_comb begin
		pkt    = bm_s1 + slot_t_s1;
		alt    = pkt + PW'(SLOT_TIME_US);
		if (alt < dmxtx_pkg::MIN_PERIOD_US) begin
			alt = dmxtx_pkg::MIN_PERIOD_US;
		end
		req_ok = (req_s1 != 20'd0) && (PW'(req_s1) >= pkt);
		per_c  = req_ok ? PW'(req_s1) : alt;
	end

	always_ff @(posedge clk) begin
		cfg.brk_p1    <= 21'(brk_s1) + 21'd1;
		cfg.mab_p1    <= 21'(mab_s1) + 21'd1;
		cfg.slots     <= slots_s1;
		cfg.period    <= per_c;
		cfg.period_p4 <= per_c + PW'(dmxtx_pkg::START_DELAY_US);
	end

endmodule

### hw/rtl/dmxtx_slot_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DMX512 transmitter slot memory
// Synchronous slot store with a clearing sweep after reset.
// ----------------------------------------------------------------------------
module dmxtx_slot_ram #(
	parameter int unsigned MAX_SLOTS = 512,
	parameter int unsigned AW        = 9
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data,
	output logic          clearing
);

	logic [7:0]    mem [MAX_SLOTS];
	logic [AW-1:0] clr_addr_q;
	logic          clearing_q;
	logic [7:0]    rd_q;
	logic          we;
	logic [AW-1:0] waddr;
	logic [7:0]    wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			clearing_q <= 1'b1;
		end else if (clearing_q) begin
			if (clr_addr_q == AW'(MAX_SLOTS - 1)) begin
				clearing_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
		end
	end

	always_comb begin
		we    = clearing_q || wr_en;
		waddr = clearing_q ? clr_addr_q : wr_addr;
		wdata = clearing_q ? 8'd0 : wr_data;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[rd_addr];
	end

	assign rd_data  = rd_q;
	assign clearing = clearing_q;

endmodule

### hw/rtl/dmxtx_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DMX512 transmitter sequencer
// Frame timer and slot pointer; drives the slot memory and builds results.
// ----------------------------------------------------------------------------
module dmxtx_seq #(
	parameter int unsigned MAX_SLOTS = 512,
	parameter int unsigned AW        = 9
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  logic [1:0]      mode,
	input  logic [8:0]      slot_index,
	input  logic [7:0]      slot_value,
	input  logic            tx_ready,
	input  dmxtx_pkg::cfg_t cfg,
	input  logic [7:0]      rd_data,
	output logic            wr_en,
	output logic [AW-1:0]   wr_addr,
	output logic [7:0]      wr_data,
	output logic [AW-1:0]   rd_addr,
	output dmxtx_pkg::res_t res
);

	dmxtx_pkg::phase_t phase_q, phase_n, phase_a;
	logic [31:0] now_q, now_n;
	logic [31:0] deadline_q, deadline_n;
	logic [31:0] bs_q, bs_n;
	logic        armed_q, armed_n;
	logic        stop_q, stop_n, stop_a;
	logic [9:0]  pos_q, pos_n, pos_a, pos_d;

	logic [31:0] now_inc;
	logic        expire;
	logic        idle_like;
	logic [9:0]  frame_len;
	logic        load_ok;
	logic        overrun;
	logic        bvalid;
	logic [7:0]  bval;

	always_comb begin
		now_inc   = now_q + 32'd1;
		expire    = armed_q && (now_inc == deadline_q);
		idle_like = (phase_q == dmxtx_pkg::PH_IDLE) || (phase_q == dmxtx_pkg::PH_INTER);
		frame_len = cfg.slots + 10'd1;
		load_ok   = 1'b0;
		overrun   = 1'b0;
		bvalid    = 1'b0;
		bval      = 8'd0;

		phase_a    = phase_q;
		now_n      = now_q;
		deadline_n = deadline_q;
		bs_n       = bs_q;
		armed_n    = armed_q;
		stop_a     = stop_q;
		pos_a      = pos_q;

		unique case (dmxtx_pkg::mode_t'(mode))
			dmxtx_pkg::MODE_TICK: begin
				now_n = now_inc;
				if (expire) begin
					unique case (phase_q)
						dmxtx_pkg::PH_BREAK: begin
							deadline_n = now_q + 32'(cfg.mab_p1);
							phase_a    = dmxtx_pkg::PH_MAB;
						end
						dmxtx_pkg::PH_MAB: begin
							deadline_n = bs_q + 32'(cfg.period);
							pos_a      = 10'd0;
							phase_a    = dmxtx_pkg::PH_DATA;
						end
						dmxtx_pkg::PH_DATA: begin
							overrun = 1'b1;
						end
						default: begin
							bs_n       = now_inc;
							deadline_n = now_q + 32'(cfg.brk_p1);
							phase_a    = dmxtx_pkg::PH_BREAK;
						end
					endcase
				end
			end
			dmxtx_pkg::MODE_LOAD: begin
				load_ok = idle_like && (32'(slot_index) < MAX_SLOTS);
			end
			dmxtx_pkg::MODE_START: begin
				if ((phase_q == dmxtx_pkg::PH_IDLE) && !armed_q) begin
					if ((now_q - bs_q) > 32'(cfg.period)) begin
						deadline_n = now_q + dmxtx_pkg::START_DELAY_US;
					end else begin
						deadline_n = bs_q + 32'(cfg.period_p4);
					end
					armed_n = 1'b1;
				end
			end
			dmxtx_pkg::MODE_STOP: begin
				if (idle_like) begin
					phase_a = dmxtx_pkg::PH_IDLE;
					armed_n = 1'b0;
					stop_a  = 1'b0;
				end else begin
					stop_a = 1'b1;
				end
			end
			default: begin
				now_n = now_q;
			end
		endcase

		// Byte hand-off uses the phase left by the item's own action.
		phase_n = phase_a;
		stop_n  = stop_a;
		pos_n   = pos_a;
		if ((phase_a == dmxtx_pkg::PH_DATA) && tx_ready) begin
			if (pos_a < frame_len) begin
				bvalid = 1'b1;
				bval   = (pos_a != 10'd0) ? rd_data : 8'd0;
				pos_n  = pos_a + 10'd1;
			end
			if (pos_n >= frame_len) begin
				if (stop_a) begin
					phase_n = dmxtx_pkg::PH_IDLE;
					armed_n = 1'b0;
					stop_n  = 1'b0;
				end else begin
					phase_n = dmxtx_pkg::PH_INTER;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= dmxtx_pkg::PH_IDLE;
			now_q      <= 32'd0;
			deadline_q <= 32'd0;
			bs_q       <= 32'd0;
			armed_q    <= 1'b0;
			stop_q     <= 1'b0;
			pos_q      <= 10'd0;
		end else if (accept) begin
			phase_q    <= phase_n;
			now_q      <= now_n;
			deadline_q <= deadline_n;
			bs_q       <= bs_n;
			armed_q    <= armed_n;
			stop_q     <= stop_n;
			pos_q      <= pos_n;
		end
	end

	// Prefetch the slot behind the next pointer value, so the byte is ready
	// by the time the following item arrives. The store is never written
	// while data is being sent, so the prefetched byte cannot go stale.
	always_comb begin
		pos_d   = accept ? pos_n : pos_q;
		rd_addr = AW'(pos_d - 10'd1);
		wr_en   = accept && load_ok;
		wr_addr = AW'(slot_index);
		wr_data = slot_value;
	end

	always_comb begin
		res.break_active   = (phase_n == dmxtx_pkg::PH_BREAK);
		res.byte_valid     = bvalid;
		res.byte_value     = bval;
		res.load_accepted  = load_ok;
		res.period_overrun = overrun;
		res.phase          = phase_n;
	end

endmodule

### hw/rtl/dmxtx_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DMX512 transmitter output buffer
// Two-entry result buffer: an output register plus a skid entry.
// ----------------------------------------------------------------------------
module dmxtx_out_buf (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  dmxtx_pkg::res_t push_data,
	input  logic            out_stall,
	output logic            out_valid,
	output dmxtx_pkg::res_t out_data,
	output logic            full
);

	dmxtx_pkg::res_t main_q;
	dmxtx_pkg::res_t skid_q;
	logic            main_v_q;
	logic            skid_v_q;
	logic            pop;

	assign pop = main_v_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (pop) begin
			if (skid_v_q) begin
				skid_v_q <= 1'b0;
			end else begin
				main_v_q <= push;
			end
		end else if (push) begin
			if (main_v_q) begin
				skid_v_q <= 1'b1;
			end else begin
				main_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			main_q <= skid_v_q ? skid_q : push_data;
		end else if (push && !main_v_q) begin
			main_q <= push_data;
		end
		if (push && main_v_q && !pop) begin
			skid_q <= push_data;
		end
	end

	assign out_valid = main_v_q;
	assign out_data  = main_q;
	assign full      = skid_v_q;

endmodule

### hw/rtl/dmx512_frame_transmitter_core.sv
`timescale 1ns / 1ps
// Result path: each result is registered in the output buffer before it is presented.
// Throughput: one transaction per cycle while in_stall is low; the slot byte for
// the next pointer value is prefetched on the read port of the slot memory while
// the current item is handled. Reset: control state clears at once, then a sweep
// zeroes the slot memory one entry per cycle with the input stalled. A register
// write stalls the input while the derived timing values settle.
// ----------------------------------------------------------------------------
// DMX512 frame transmitter core
// Sequences BREAK, mark-after-break, start code and slot bytes on a
// microsecond tick, with an APB port for the timing registers.
// ----------------------------------------------------------------------------
module dmx512_frame_transmitter_core #(
	parameter int unsigned MAX_SLOTS    = 512,
	parameter int unsigned SLOT_TIME_US = 44
) (
	input  logic        clk,
	input  logic        arst_n,

	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,

	// Input channel: one transaction is a tick, load, start or stop item.
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [8:0]  slot_index,
	input  logic [7:0]  slot_value,
	input  logic        tx_ready,

	// Output channel: exactly one result transaction per input transaction.
	output logic        out_valid,
	input  logic        out_stall,
	output logic        break_active,
	output logic        byte_valid,
	output logic [7:0]  byte_value,
	output logic        load_accepted,
	output logic        period_overrun,
	output logic [2:0]  phase
);

	// Slot memory address width; at least one bit for a single-slot build.
	localparam int unsigned AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

	dmxtx_pkg::cfg_t cfg;
	dmxtx_pkg::res_t res;
	dmxtx_pkg::res_t out_res;
	logic            cfg_hold;
	logic            clearing;
	logic            buf_full;
	logic            accept;
	logic            wr_en;
	logic [AW-1:0]   wr_addr;
	logic [7:0]      wr_data;
	logic [AW-1:0]   rd_addr;
	logic [7:0]      rd_data;

	// The register file never waits.
	assign pready = 1'b1;

	dmxtx_cfg #(
		.MAX_SLOTS   (MAX_SLOTS),
		.SLOT_TIME_US(SLOT_TIME_US)
	) u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.hold   (cfg_hold),
		.cfg    (cfg)
	);

	// Input stalls only while the result buffer holds two results, while the
	// slot memory is being cleared, or right after a register write. The stall
	// comes from registers alone, so there is no path from out_stall to it.
	assign in_stall = buf_full || clearing || cfg_hold;
	assign accept   = in_valid && !in_stall;

	dmxtx_slot_ram #(
		.MAX_SLOTS(MAX_SLOTS),
		.AW       (AW)
	) u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.clearing(clearing)
	);

	// The sequencer computes each result in the cycle of its transaction, from
	// the timer state and the prefetched slot byte.
	dmxtx_seq #(
		.MAX_SLOTS(MAX_SLOTS),
		.AW       (AW)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.mode      (mode),
		.slot_index(slot_index),
		.slot_value(slot_value),
		.tx_ready  (tx_ready),
		.cfg       (cfg),
		.rd_data   (rd_data),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_addr   (rd_addr),
		.res       (res)
	);

	// Results wait here; the skid entry lets a new item in while the output
	// register is held by a stalled receiver.
	dmxtx_out_buf u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.push_data(res),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.out_data (out_res),
		.full     (buf_full)
	);

	assign break_active   = out_res.break_active;
	assign byte_valid     = out_res.byte_valid;
	assign byte_value     = out_res.byte_value;
	assign load_accepted  = out_res.load_accepted;
	assign period_overrun = out_res.period_overrun;
	assign phase          = out_res.phase;

endmodule
